/* hdl/assert_macros.svh */
// Assertion macros for the feedback echo delay RTL, included by fed_core.
// Assumes the including module has a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FED_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FED_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/fed_pkg.sv */
// Shared types and constants for the feedback echo delay block.
// No dependencies; used by feedback_echo_delay, fed_csr and fed_core (not fed_delay_mem).
package fed_pkg;

   localparam int DEFAULT_MAX_DELAY   = 16384;
   localparam int DEFAULT_SAMPLE_BITS = 16;

   localparam int CFG_LEN_W  = 15;
   localparam int GAIN_W     = 16;
   localparam int GAIN_ONE   = 32768;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_LEN_W-1:0] RESET_DELAY_LENGTH  = 15'd13230;
   localparam logic [GAIN_W-1:0]    RESET_FEEDBACK_GAIN = 16'd16384;
   localparam logic [GAIN_W-1:0]    RESET_MIX_LEVEL     = 16'd16384;

   typedef enum logic [1:0] {
      REG_DELAY_LENGTH  = 2'd0,
      REG_FEEDBACK_GAIN = 2'd1,
      REG_MIX_LEVEL     = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEEDBACK,
      ST_SUM,
      ST_MIX
   } fed_state_type;

   typedef struct packed {
      logic [CFG_LEN_W-1:0] delay_length;
      logic [GAIN_W-1:0]    feedback_gain;
      logic [GAIN_W-1:0]    mix_level;
   } fed_cfg_type;

endpackage

/* hdl/feedback_echo_delay.sv */
// Feedback echo delay, top level: one signed sample in, one echoed and mixed sample out.
// Depends on fed_pkg, fed_csr, fed_delay_mem and fed_core.
//
// Steps per sample, in order: accept with the delay-line read, feedback multiply
// (with the dry-path multiply alongside), saturated sum written back to the delay line,
// then the wet multiply and mix into the output register. The single-port delay RAM and
// the shared sequencer handle one sample at a time; a new sample is accepted while the
// previous result still waits in the output register, and the mix step holds only if
// that register is still full. The delay line reads as zero until written: a fill count
// tracks written entries, so no clearing pass is needed after reset.
module feedback_echo_delay
   import fed_pkg::*;
#(
   parameter int MAX_DELAY   = DEFAULT_MAX_DELAY,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,   // [SAMPLE_BITS-1:0] sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,   // [SAMPLE_BITS-1:0] sample_out
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]             csr_paddr,
   input  logic [CSR_DATA_W-1:0]             csr_pwdata,
   output logic [CSR_DATA_W-1:0]             csr_prdata,
   output logic                              csr_pready
);

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PTR_W  = $clog2(MAX_DELAY);

   fed_cfg_type            cfg;
   logic                   mem_rd_en;
   logic                   mem_wr_en;
   logic [PTR_W-1:0]       mem_addr;
   logic [SAMPLE_BITS-1:0] mem_wr_data;
   logic [SAMPLE_BITS-1:0] mem_rd_data;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   fed_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fed_delay_mem #(
      .DEPTH (MAX_DELAY),
      .WIDTH (SAMPLE_BITS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   fed_core #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sample  (rsp_sample),
      .mem_rd_en   (mem_rd_en),
      .mem_wr_en   (mem_wr_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   assign rsp_tdata = DATA_W'(rsp_sample);

endmodule

/* hdl/fed_csr.sv */
// APB-style register file: delay length, feedback gain, mix level.
// Depends on fed_pkg; feeds the raw register values to fed_core.
module fed_csr
   import fed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output fed_cfg_type           cfg
);

   logic [CFG_LEN_W-1:0] delay_length_ff, delay_length_in;
   logic [GAIN_W-1:0]    feedback_gain_ff, feedback_gain_in;
   logic [GAIN_W-1:0]    mix_level_ff, mix_level_in;
   logic                 wr_stb;
   reg_index_type        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      delay_length_in  = delay_length_ff;
      feedback_gain_in = feedback_gain_ff;
      mix_level_in     = mix_level_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_DELAY_LENGTH:  delay_length_in  = csr_pwdata[CFG_LEN_W-1:0];
            REG_FEEDBACK_GAIN: feedback_gain_in = csr_pwdata[GAIN_W-1:0];
            REG_MIX_LEVEL:     mix_level_in     = csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DELAY_LENGTH:  csr_prdata = CSR_DATA_W'(delay_length_ff);
         REG_FEEDBACK_GAIN: csr_prdata = CSR_DATA_W'(feedback_gain_ff);
         REG_MIX_LEVEL:     csr_prdata = CSR_DATA_W'(mix_level_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff  <= RESET_DELAY_LENGTH;
         feedback_gain_ff <= RESET_FEEDBACK_GAIN;
         mix_level_ff     <= RESET_MIX_LEVEL;
      end else begin
         delay_length_ff  <= delay_length_in;
         feedback_gain_ff <= feedback_gain_in;
         mix_level_ff     <= mix_level_in;
      end
   end

   assign cfg.delay_length  = delay_length_ff;
   assign cfg.feedback_gain = feedback_gain_ff;
   assign cfg.mix_level     = mix_level_ff;

endmodule

/* hdl/fed_delay_mem.sv */
// Single-port synchronous delay-line RAM with a registered read.
// Depends on nothing; driven by fed_core.
module fed_delay_mem #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fed_core.sv */
// Sequencer and datapath: read delayed sample, feedback multiply, write back, wet/dry mix.
// Depends on fed_pkg and assert_macros.svh; drives fed_delay_mem.
`include "assert_macros.svh"

module fed_core
   import fed_pkg::*;
#(
   parameter int MAX_DELAY   = DEFAULT_MAX_DELAY,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fed_cfg_type                  cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [SAMPLE_BITS-1:0]       req_sample,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [SAMPLE_BITS-1:0]       rsp_sample,
   output logic                         mem_rd_en,
   output logic                         mem_wr_en,
   output logic [$clog2(MAX_DELAY)-1:0] mem_addr,
   output logic [SAMPLE_BITS-1:0]       mem_wr_data,
   input  logic [SAMPLE_BITS-1:0]       mem_rd_data
);

   localparam int SB     = SAMPLE_BITS;
   localparam int PTR_W  = $clog2(MAX_DELAY);
   localparam int CNT_W  = $clog2(MAX_DELAY + 1);
   localparam int LEN_W  = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;
   localparam int GS_W   = GAIN_W + 1;
   localparam int PROD_W = SB + GS_W;
   localparam int ACC_W  = SB + GS_W + 1;
   localparam logic [GAIN_W-1:0]     GAIN_MAX  = GAIN_W'(GAIN_ONE);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(GAIN_ONE / 2);

   function automatic logic [SB-1:0] sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = $signed({{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         sat = hi[SB-1:0];
      end else if (v < lo) begin
         sat = lo[SB-1:0];
      end else begin
         sat = v[SB-1:0];
      end
   endfunction

   fed_state_type state_ff, state_in;

   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;       // entries [0, fill) have been written
   logic                     rd_valid_ff, rd_valid_in;
   logic signed [SB-1:0]     x_ff, x_in;
   logic signed [PROD_W-1:0] fb_prod_ff, fb_prod_in;
   logic signed [PROD_W-1:0] dry_ff, dry_in;
   logic signed [SB-1:0]     sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]            rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0]         len_raw, len_eff, ptr_inc;
   logic [GAIN_W-1:0]        fb_gain, mix_gain;
   logic signed [GS_W-1:0]   fb_s, mix_s, dry_s;
   logic signed [SB-1:0]     delayed;
   logic signed [ACC_W-1:0]  fb_round, sum_wide, acc, acc_round;
   logic [SB-1:0]            sum_sat;
   logic                     req_acc;
   logic                     out_free;

   // Effective configuration
   always_comb begin
      len_raw = LEN_W'(cfg.delay_length);
      if (len_raw == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_raw > LEN_W'(MAX_DELAY)) begin
         len_eff = LEN_W'(MAX_DELAY);
      end else begin
         len_eff = len_raw;
      end
      fb_gain  = (cfg.feedback_gain > GAIN_MAX) ? GAIN_MAX : cfg.feedback_gain;
      mix_gain = (cfg.mix_level > GAIN_MAX) ? GAIN_MAX : cfg.mix_level;
   end

   assign fb_s    = $signed({1'b0, fb_gain});
   assign mix_s   = $signed({1'b0, mix_gain});
   assign dry_s   = $signed(GS_W'(GAIN_ONE)) - mix_s;
   assign delayed = rd_valid_ff ? $signed(mem_rd_data) : '0;
   assign ptr_inc = LEN_W'(ptr_ff) + LEN_W'(1);

   // round half up: add half an LSB then floor shift
   assign fb_round  = (ACC_W'(fb_prod_ff) + ROUND_HALF) >>> 15;
   assign sum_wide  = fb_round + ACC_W'(x_ff);
   assign sum_sat   = sat(sum_wide);
   assign acc       = ACC_W'(dry_ff) + ACC_W'(sum_ff * mix_s);
   assign acc_round = (acc + ROUND_HALF) >>> 15;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      rd_valid_in  = rd_valid_ff;
      x_in         = x_ff;
      fb_prod_in   = fb_prod_ff;
      dry_in       = dry_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_addr     = ptr_ff;
      mem_wr_data  = sum_sat;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               x_in        = $signed(req_sample);
               mem_rd_en   = 1'b1;
               rd_valid_in = CNT_W'(ptr_ff) < fill_ff;
               state_in    = ST_FEEDBACK;
            end
         end
         ST_FEEDBACK: begin
            fb_prod_in = delayed * fb_s;
            dry_in     = x_ff * dry_s;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            mem_wr_en = 1'b1;
            sum_in    = $signed(sum_sat);
            if (CNT_W'(ptr_ff) == fill_ff) begin
               fill_in = fill_ff + CNT_W'(1);
            end
            ptr_in   = (ptr_inc >= len_eff) ? '0 : ptr_inc[PTR_W-1:0];
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat(acc_round);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= rd_valid_in;
      x_ff        <= x_in;
      fb_prod_ff  <= fb_prod_in;
      dry_ff      <= dry_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sample = rsp_data_ff;

   `FED_ASSERT(a_ptr_within_fill, CNT_W'(ptr_ff) <= fill_ff, "write pointer ran past fill count")
   `FED_ASSERT(a_fill_bound, fill_ff <= CNT_W'(MAX_DELAY), "fill count exceeds delay line depth")
   `FED_ASSERT(a_wr_only_in_sum, mem_wr_en |-> (state_ff == ST_SUM && !mem_rd_en), "stray delay line write")
   `FED_ASSERT(a_rsp_from_mix, $rose(rsp_valid_ff) |-> $past(state_ff == ST_MIX), "result loaded outside mix step")

endmodule
